[design/rmfb_pkg.sv]
// Shared types, codes and constants for the radio module frame builder.
package rmfb_pkg;

  localparam logic [1:0] OP_GENERAL = 2'd0;
  localparam logic [1:0] OP_XFER    = 2'd1;
  localparam logic [1:0] OP_PAYLOAD = 2'd2;

  localparam logic [7:0] START_BYTE   = 8'h6C;
  localparam logic [7:0] FIXED_BYTE   = 8'h09;
  localparam logic [7:0] END_BYTE     = 8'h16;
  localparam logic [7:0] MAIN_ROUTE0  = 8'h80;
  localparam logic [7:0] MAIN_ROUTE1  = 8'h88;
  localparam logic [7:0] OTHER_ROUTE0 = 8'h00;
  localparam logic [7:0] OTHER_ROUTE1 = 8'h99;
  localparam logic [7:0] PREFIX_ZERO  = 8'h00;
  localparam logic [7:0] PREFIX_TAG   = 8'h30;
  localparam logic [15:0] XFER_COMMAND = 16'h0305;

  localparam logic [7:0] GEN_MAX_LEN     = 8'd250;
  localparam logic [7:0] XFER_MAX_LEN    = 8'd241;
  localparam logic [7:0] HEADER_LEN      = 8'd5;
  localparam logic [7:0] XFER_PREFIX_LEN = 8'd9;

  localparam logic [4:0] GEN_BODY_BYTES  = 5'd8;
  localparam logic [4:0] XFER_BODY_BYTES = 5'd17;
  localparam logic [4:0] ONE_BYTE        = 5'd1;
  localparam logic [4:0] CLOSE_BYTES     = 5'd2;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] command;
    logic        to_main;
    logic [47:0] dest_address;
    logic [7:0]  length;
    logic [7:0]  data_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
    logic       error;
  } out_item_t;

  typedef enum logic [1:0] {
    JOB_ERROR,
    JOB_GENERAL,
    JOB_XFER,
    JOB_PAYLOAD
  } job_kind_t;

  typedef struct packed {
    job_kind_t   kind;
    logic        close;
    logic [7:0]  len_byte;
    logic [15:0] command;
    logic        to_main;
    logic [47:0] dest_address;
    logic [7:0]  length;
    logic [7:0]  data_byte;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

endpackage

[design/radio_module_frame_builder.sv]
// Top level of the radio module frame builder: front end, job queue, byte sequencer.
// An accepted item is written to the job queue, then its first byte to the output register.
// One result byte per cycle unless result_stall holds it; an item holds the sequencer until
// it has yielded all its bytes (1 for a plain payload byte or error, up to 19 for a transfer
// begin). Unstalled, plain payload bytes sustain one item per cycle via the 4-entry queue.
// Reset clears the open frame, byte count, checksum, queue and the output valid flag.
module radio_module_frame_builder import rmfb_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      item_valid,
  output logic      item_stall,
  input  in_item_t  item,
  output logic      result_valid,
  input  logic      result_stall,
  output out_item_t result
);

  logic        push;
  job_t        push_job;
  logic        pop;
  job_t        head;
  queue_stat_t qstat;

  rmfb_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .qstat      (qstat),
    .push       (push),
    .push_job   (push_job)
  );

  rmfb_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .qstat    (qstat)
  );

  rmfb_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .qstat        (qstat),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  a_error_closes: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.error |-> result.last && result.out_byte == 8'd0)
    else $error("error transaction without last or with nonzero byte");

  a_reset_idle: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid right after reset");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !qstat.empty)
    else $error("job queue popped while empty");

  a_stall_when_full: assert property (@(posedge clk) disable iff (rst)
    qstat.full |-> item_stall && !push)
    else $error("job queue written while full");

endmodule

[design/rmfb_front.sv]
// Front end: accepts input items, tracks the open frame and queues jobs.
module rmfb_front import rmfb_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_stall,
  input  in_item_t    item,
  input  queue_stat_t qstat,
  output logic        push,
  output job_t        push_job
);

  logic       frame_open;
  logic       frame_open_next;
  logic [7:0] bytes_left;
  logic [7:0] bytes_left_next;

  assign item_stall = qstat.full;
  assign push       = item_valid && !qstat.full;

  always_comb begin
    push_job.kind         = JOB_ERROR;
    push_job.close        = 1'b0;
    push_job.len_byte     = HEADER_LEN + item.length;
    push_job.command      = item.command;
    push_job.to_main      = item.to_main;
    push_job.dest_address = item.dest_address;
    push_job.length       = item.length;
    push_job.data_byte    = item.data_byte;
    frame_open_next       = frame_open;
    bytes_left_next       = bytes_left;
    case (item.op)
      OP_GENERAL: begin
        if (item.length <= GEN_MAX_LEN) begin
          push_job.kind   = JOB_GENERAL;
          push_job.close  = (item.length == 8'd0);
          frame_open_next = (item.length != 8'd0);
          bytes_left_next = item.length;
        end
      end
      OP_XFER: begin
        if (item.length <= XFER_MAX_LEN) begin
          push_job.kind     = JOB_XFER;
          push_job.close    = (item.length == 8'd0);
          push_job.command  = XFER_COMMAND;
          push_job.to_main  = 1'b1;
          push_job.len_byte = HEADER_LEN + XFER_PREFIX_LEN + item.length;
          frame_open_next   = (item.length != 8'd0);
          bytes_left_next   = item.length;
        end
      end
      OP_PAYLOAD: begin
        if (frame_open) begin
          push_job.kind   = JOB_PAYLOAD;
          push_job.close  = (bytes_left == 8'd1);
          frame_open_next = (bytes_left != 8'd1);
          bytes_left_next = bytes_left - 8'd1;
        end
      end
      default: begin
        push_job.kind = JOB_ERROR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_open <= 1'b0;
      bytes_left <= 8'd0;
    end else if (push) begin
      frame_open <= frame_open_next;
      bytes_left <= bytes_left_next;
    end
  end

endmodule

[design/rmfb_queue.sv]
// Job queue between the front end and the byte sequencer.
module rmfb_queue import rmfb_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  job_t        push_job,
  input  logic        pop,
  output job_t        head,
  output queue_stat_t qstat
);

  job_t                entries [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QUEUE_AW:0]   count;

  assign qstat.full  = (count == QUEUE_AW'(0) + (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign qstat.empty = (count == '0);
  assign head        = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QUEUE_AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QUEUE_AW'(1);
      end
      if (push && !pop) begin
        count <= count + (QUEUE_AW+1)'(1);
      end else if (pop && !push) begin
        count <= count - (QUEUE_AW+1)'(1);
      end
    end
  end

endmodule

[design/rmfb_back.sv]
// Back end: expands queued jobs into frame bytes with the running checksum.
module rmfb_back import rmfb_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  job_t        head,
  input  queue_stat_t qstat,
  output logic        pop,
  output logic        result_valid,
  input  logic        result_stall,
  output out_item_t   result
);

  logic [4:0] idx;
  logic [7:0] running_sum;
  logic [7:0] running_sum_next;
  logic [4:0] body_count;
  logic [4:0] last_idx;
  logic [7:0] body_byte;
  out_item_t  nxt_item;
  logic       advance;
  logic       emit;

  assign advance = !result_valid || !result_stall;
  assign emit    = advance && !qstat.empty;
  assign pop     = emit && (idx == last_idx);

  always_comb begin
    case (head.kind)
      JOB_GENERAL: body_count = GEN_BODY_BYTES;
      JOB_XFER:    body_count = XFER_BODY_BYTES;
      default:     body_count = ONE_BYTE;
    endcase
    if (head.close && head.kind != JOB_ERROR) begin
      last_idx = body_count + CLOSE_BYTES - 5'd1;
    end else begin
      last_idx = body_count - 5'd1;
    end
  end

  always_comb begin
    case (idx)
      5'd0:    body_byte = START_BYTE;
      5'd1:    body_byte = head.len_byte;
      5'd2:    body_byte = FIXED_BYTE;
      5'd3:    body_byte = head.command[15:8];
      5'd4:    body_byte = head.command[7:0];
      5'd5:    body_byte = head.to_main ? MAIN_ROUTE0 : OTHER_ROUTE0;
      5'd6:    body_byte = head.to_main ? MAIN_ROUTE1 : OTHER_ROUTE1;
      5'd7:    body_byte = head.to_main ? MAIN_ROUTE1 : OTHER_ROUTE1;
      5'd8:    body_byte = head.dest_address[47:40];
      5'd9:    body_byte = head.dest_address[39:32];
      5'd10:   body_byte = head.dest_address[31:24];
      5'd11:   body_byte = head.dest_address[23:16];
      5'd12:   body_byte = head.dest_address[15:8];
      5'd13:   body_byte = head.dest_address[7:0];
      5'd14:   body_byte = PREFIX_ZERO;
      5'd15:   body_byte = PREFIX_TAG;
      5'd16:   body_byte = head.length;
      default: body_byte = 8'd0;
    endcase
    if (head.kind == JOB_PAYLOAD) begin
      body_byte = head.data_byte;
    end
  end

  always_comb begin
    nxt_item.out_byte = 8'd0;
    nxt_item.last     = 1'b0;
    nxt_item.error    = 1'b0;
    running_sum_next  = running_sum;
    if (head.kind == JOB_ERROR) begin
      nxt_item.last  = 1'b1;
      nxt_item.error = 1'b1;
    end else if (idx < body_count) begin
      nxt_item.out_byte = body_byte;
      if (idx == 5'd0 && head.kind != JOB_PAYLOAD) begin
        running_sum_next = body_byte;
      end else begin
        running_sum_next = running_sum + body_byte;
      end
    end else if (idx == body_count) begin
      nxt_item.out_byte = running_sum;
    end else begin
      nxt_item.out_byte = END_BYTE;
      nxt_item.last     = 1'b1;
      running_sum_next  = 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      result <= nxt_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      idx          <= '0;
      running_sum  <= 8'd0;
    end else if (emit) begin
      result_valid <= 1'b1;
      running_sum  <= running_sum_next;
      idx          <= pop ? 5'd0 : idx + 5'd1;
    end else if (advance) begin
      result_valid <= 1'b0;
    end
  end

endmodule
